### design/line_follow_steering_core_assert.svh
// Assertion macros shared by the line-follow steering RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef LINE_FOLLOW_STEERING_CORE_ASSERT_SVH
`define LINE_FOLLOW_STEERING_CORE_ASSERT_SVH

// same-cycle implication
`define LFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfs assertion failed");

// next-cycle implication
`define LFS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfs assertion failed");

`endif

### design/lfs_pkg.sv
// Package for the line-follow steering core: payload types, codes, level table.
// No dependencies.
`default_nettype none

package lfs_pkg;

  localparam int unsigned SpeedMax = 99;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SEARCH_LIMIT = 1'b0;
  localparam cfg_idx_t CFG_STEP_GAIN    = 1'b1;

  localparam logic [7:0] SEARCH_LIMIT_RST = 8'd125;
  localparam logic [3:0] STEP_GAIN_RST    = 4'd1;

  localparam logic [3:0] PAT_ALL_WHITE  = 4'd0;
  localparam logic [3:0] PAT_FRONT_LOST = 4'd3;
  localparam logic [3:0] PAT_HALF_RIGHT = 4'd6;
  localparam logic [3:0] PAT_HALF_LEFT  = 4'd9;
  localparam logic [3:0] PAT_REAR_LOST  = 4'd12;

  // side memory: 0 none, +1 right, -1 left
  localparam logic signed [1:0] SIDE_NONE  = 2'sb00;
  localparam logic signed [1:0] SIDE_RIGHT = 2'sb01;
  localparam logic signed [1:0] SIDE_LEFT  = 2'sb11;

  typedef struct packed {
    logic       front_left_black;
    logic       front_right_black;
    logic       rear_left_black;
    logic       rear_right_black;
    logic       frame_valid;
    logic [7:0] base_speed;
  } lfs_req_t;

  typedef struct packed {
    logic       drive;
    logic [6:0] left_speed;
    logic [6:0] right_speed;
  } lfs_res_t;

  // fixed steering levels; the all-white and lost-pair entries come from side memory
  function automatic logic signed [4:0] level_lut(input logic [3:0] pat);
    logic signed [4:0] lvl;
    case (pat)
      4'd1:    lvl = 5'sd3;
      4'd2:    lvl = -5'sd3;
      4'd4:    lvl = 5'sd2;
      4'd5:    lvl = 5'sd1;
      4'd6:    lvl = 5'sd5;
      4'd7:    lvl = 5'sd3;
      4'd8:    lvl = -5'sd2;
      4'd9:    lvl = -5'sd5;
      4'd10:   lvl = -5'sd1;
      4'd11:   lvl = -5'sd3;
      4'd13:   lvl = -5'sd2;
      4'd14:   lvl = 5'sd2;
      default: lvl = 5'sd0;
    endcase
    return lvl;
  endfunction

  function automatic logic [6:0] clamp_speed(input logic signed [10:0] v);
    logic [6:0] r;
    if (v < 0) begin
      r = 7'd0;
    end else if (v > 11'(SpeedMax)) begin
      r = 7'(SpeedMax);
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/lfs_req_if.sv
// Sensor frame request channel: valid/ready plus one frame.
// Depends on lfs_pkg.
`default_nettype none

interface lfs_req_if;
  logic              valid;
  logic              ready;
  lfs_pkg::lfs_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/lfs_res_if.sv
// Wheel command result channel: valid/ready plus drive and speeds.
// Depends on lfs_pkg.
`default_nettype none

interface lfs_res_if;
  logic              valid;
  logic              ready;
  lfs_pkg::lfs_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/line_follow_steering_core.sv
// Path from request accept to result valid: input reg, then result reg.
// Throughput: one request per cycle; input reg takes a new request while a
// result waits, and the pair stalls only when both hold data.
// Reset (async, low): side memory and white count clear, search_limit = 125,
// step_gain = 1, both pipeline slots empty.
// Steering core for a line follower. Depends on lfs_pkg, lfs_req_if, lfs_res_if
// and line_follow_steering_core_assert.svh.
`default_nettype none

module line_follow_steering_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  lfs_req_if.sink              req_i,
  lfs_res_if.source            res_o,
  input  wire logic            cfg_we_i,
  input  wire lfs_pkg::cfg_idx_t cfg_idx_i,
  input  wire logic [7:0]      cfg_wdata_i
);
  import lfs_pkg::*;

  logic [7:0] search_limit_q;
  logic [3:0] step_gain_q;

  logic             in_valid_q;
  lfs_req_t         in_q;
  logic             out_valid_q;
  lfs_res_t         out_q;

  logic signed [1:0] front_q, front_d;
  logic signed [1:0] rear_q, rear_d;
  logic [7:0]        cnt_q, cnt_d;

  logic              advance;
  logic              in_ready;
  logic [3:0]        pat;
  logic              active;
  logic              stop;
  logic [8:0]        cnt_inc;
  logic signed [4:0] level;
  logic signed [4:0] front_x, rear_x;
  logic signed [9:0] boost;
  logic signed [10:0] spd, bst, left_v, right_v;
  lfs_res_t          res_d;

  assign advance  = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_ready = !in_valid_q || advance;

  assign req_i.ready = in_ready;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_comb begin
    pat     = {in_q.front_left_black, in_q.front_right_black,
               in_q.rear_left_black, in_q.rear_right_black};
    active  = in_q.frame_valid && (in_q.base_speed != 8'd0);
    cnt_inc = {1'b0, cnt_q} + 9'd1;
    front_d = front_q;
    rear_d  = rear_q;
    cnt_d   = cnt_q;
    stop    = 1'b0;

    if (!active) begin
      stop = 1'b1;
    end else if (pat == PAT_ALL_WHITE) begin
      if (front_q == SIDE_NONE && rear_q == SIDE_NONE) begin
        stop = 1'b1;
      end else begin
        cnt_d = cnt_inc[8] ? 8'hFF : cnt_inc[7:0];
        if (cnt_inc > {1'b0, search_limit_q}) begin
          stop = 1'b1;
        end
      end
    end else begin
      cnt_d = 8'd0;
      if (in_q.front_left_black != in_q.front_right_black) begin
        front_d = in_q.front_right_black ? SIDE_RIGHT : SIDE_LEFT;
      end
      if (in_q.rear_left_black != in_q.rear_right_black) begin
        rear_d = in_q.rear_right_black ? SIDE_RIGHT : SIDE_LEFT;
      end
    end

    front_x = {{3{front_d[1]}}, front_d};
    rear_x  = {{3{rear_d[1]}}, rear_d};
    case (pat)
      PAT_FRONT_LOST: level = front_x <<< 3;
      PAT_REAR_LOST:  level = -rear_x;
      PAT_ALL_WHITE:  level = (front_d != SIDE_NONE) ? (front_x <<< 3) : (rear_x <<< 3);
      default:        level = level_lut(pat);
    endcase

    boost = $signed({1'b0, step_gain_q}) * level;
    spd   = $signed({3'b000, in_q.base_speed});
    bst   = {boost[9], boost};

    if (boost > 0) begin
      if (pat == PAT_HALF_RIGHT) begin
        left_v  = spd;
        right_v = spd >>> 1;
      end else begin
        left_v  = spd + bst;
        right_v = spd;
      end
    end else begin
      if (pat == PAT_HALF_LEFT) begin
        right_v = spd;
        left_v  = spd >>> 1;
      end else begin
        left_v  = spd;
        right_v = spd - bst;
      end
    end

    if (stop) begin
      res_d = '0;
    end else begin
      res_d.drive       = 1'b1;
      res_d.left_speed  = clamp_speed(left_v);
      res_d.right_speed = clamp_speed(right_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_limit_q <= SEARCH_LIMIT_RST;
      step_gain_q    <= STEP_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEARCH_LIMIT: search_limit_q <= cfg_wdata_i;
        CFG_STEP_GAIN:    step_gain_q    <= cfg_wdata_i[3:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      front_q     <= SIDE_NONE;
      rear_q      <= SIDE_NONE;
      cnt_q       <= 8'd0;
    end else begin
      if (in_ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        front_q     <= front_d;
        rear_q      <= rear_d;
        cnt_q       <= cnt_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      in_q <= req_i.data;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

`include "line_follow_steering_core_assert.svh"

  `LFS_ASSERT_NOW(a_stop_zero, out_valid_q && !out_q.drive,
                  out_q.left_speed == 7'd0 && out_q.right_speed == 7'd0)
  `LFS_ASSERT_NOW(a_speed_range, out_valid_q,
                  out_q.left_speed <= 7'(SpeedMax) && out_q.right_speed <= 7'(SpeedMax))
  `LFS_ASSERT_NXT(a_black_clears, advance && active && pat != PAT_ALL_WHITE,
                  cnt_q == 8'd0)
  `LFS_ASSERT_NXT(a_res_kept, out_valid_q && !res_o.ready, out_valid_q)

endmodule

`default_nettype wire

### bench/lfs_wheel_checker.sv
// Wheel command checker for line_follow_steering_core: tracks register writes,
// predicts drive and wheel speeds per accepted sensor frame, compares results.
// Depends on lfs_pkg, lfs_req_if and lfs_res_if.
module lfs_wheel_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  lfs_req_if                req_mon,
  lfs_res_if                res_mon,
  input  logic              cfg_we_i,
  input  lfs_pkg::cfg_idx_t cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  output int                mismatch_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lfs_pkg::*;

  // entries for all-white, front-lost and rear-lost come from side memory
  localparam int STEER_LEVEL [16] = '{0, 3, -3, 0, 2, 1, 5, 3, -2, -5, -1, -3, 0, -2, 2, 0};
  localparam int ReportMax = 10;

  logic [7:0]        search_limit;
  logic [3:0]        step_gain;
  logic signed [1:0] front_side;
  logic signed [1:0] rear_side;
  logic [7:0]        white_count;
  lfs_res_t          expected_wheels [$];
  lfs_res_t          want;

  function automatic logic [6:0] clamp_wheel(input int v);
    if (v < 0) return 7'd0;
    if (v > int'(SpeedMax)) return 7'(SpeedMax);
    return 7'(v);
  endfunction

  function automatic lfs_res_t predict_wheels(input lfs_req_t r);
    int         speed;
    int         level;
    int         boost;
    int         left;
    int         right;
    int         next_count;
    logic [3:0] pat;
    lfs_res_t   cmd;
    cmd = '0;
    speed = int'(r.base_speed);
    pat = {r.front_left_black, r.front_right_black, r.rear_left_black, r.rear_right_black};
    if (!r.frame_valid || speed == 0) return cmd;
    if (pat == PAT_ALL_WHITE) begin
      if (front_side == SIDE_NONE && rear_side == SIDE_NONE) return cmd;
      next_count = int'(white_count) + 1;
      white_count = (next_count > 255) ? 8'd255 : 8'(next_count);
      if (next_count > int'(search_limit)) return cmd;
    end else begin
      white_count = '0;
    end
    if (r.front_left_black != r.front_right_black) begin
      front_side = r.front_right_black ? SIDE_RIGHT : SIDE_LEFT;
    end
    if (r.rear_left_black != r.rear_right_black) begin
      rear_side = r.rear_right_black ? SIDE_RIGHT : SIDE_LEFT;
    end
    case (pat)
      PAT_FRONT_LOST: level = 8 * int'(front_side);
      PAT_REAR_LOST:  level = -int'(rear_side);
      PAT_ALL_WHITE:  level = 8 * ((front_side != SIDE_NONE) ? int'(front_side) : int'(rear_side));
      default:        level = STEER_LEVEL[pat];
    endcase
    boost = int'(step_gain) * level;
    if (boost > 0) begin
      if (pat == PAT_HALF_RIGHT) begin
        left = speed;
        right = speed / 2;
      end else begin
        left = speed + boost;
        right = speed;
      end
    end else begin
      if (pat == PAT_HALF_LEFT) begin
        right = speed;
        left = speed / 2;
      end else begin
        left = speed;
        right = speed - boost;
      end
    end
    cmd.drive = 1'b1;
    cmd.left_speed = clamp_wheel(left);
    cmd.right_speed = clamp_wheel(right);
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_limit = SEARCH_LIMIT_RST;
      step_gain = STEP_GAIN_RST;
      front_side = SIDE_NONE;
      rear_side = SIDE_NONE;
      white_count = '0;
      expected_wheels.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_wheels.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= ReportMax) begin
            $display("%0t: unexpected result drive=%0d left=%0d right=%0d", $realtime,
                     res_mon.data.drive, res_mon.data.left_speed, res_mon.data.right_speed);
          end
        end else begin
          want = expected_wheels.pop_front();
          if (res_mon.data.drive !== want.drive || res_mon.data.left_speed !== want.left_speed ||
              res_mon.data.right_speed !== want.right_speed) begin
            mismatch_count_o++;
            if (mismatch_count_o <= ReportMax) begin
              $display("%0t: mismatch expected drive=%0d left=%0d right=%0d, got %0d %0d %0d",
                       $realtime, want.drive, want.left_speed, want.right_speed,
                       res_mon.data.drive, res_mon.data.left_speed, res_mon.data.right_speed);
            end
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_wheels.push_back(predict_wheels(req_mon.data));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEARCH_LIMIT: search_limit = cfg_wdata_i;
          CFG_STEP_GAIN:    step_gain = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      pending_o = expected_wheels.size();
    end
  end

endmodule

### bench/line_follow_steering_core_tb.sv
// Top of the line_follow_steering_core bench: clock, reset, directed and random
// sensor frames, register phases, result back-pressure and the verdict.
// Depends on lfs_pkg, lfs_req_if, lfs_res_if, the core and lfs_wheel_checker.
module line_follow_steering_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfs_pkg::*;

  localparam int StallLimit = 600;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  cfg_idx_t   cfg_idx_i = CFG_SEARCH_LIMIT;
  logic [7:0] cfg_wdata_i = '0;
  bit         idle_on = 1'b1;
  int         mismatches;
  int         pending;

  lfs_req_if req_ch ();
  lfs_res_if res_ch ();

  line_follow_steering_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  lfs_wheel_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_mon         (req_ch),
    .res_mon         (res_ch),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic lfs_req_t make_frame(input logic [3:0] pat, input logic vld,
                                          input logic [7:0] spd);
    lfs_req_t f;
    f.front_left_black = pat[3];
    f.front_right_black = pat[2];
    f.rear_left_black = pat[1];
    f.rear_right_black = pat[0];
    f.frame_valid = vld;
    f.base_speed = spd;
    return f;
  endfunction

  function automatic lfs_req_t random_frame();
    logic [7:0] spd;
    case ($urandom_range(0, 9))
      0:       spd = 8'd0;
      1:       spd = 8'd255;
      2:       spd = 8'($urandom_range(100, 255));
      default: spd = 8'($urandom_range(1, 99));
    endcase
    return make_frame(4'($urandom_range(0, 15)), $urandom_range(0, 9) != 0, spd);
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_frame(input lfs_req_t f);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid = 1'b1;
    req_ch.data = f;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    req_ch.valid = 1'b0;
  endtask

  task automatic settle();
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] limit, input logic [7:0] gain);
    settle();
    write_reg(CFG_SEARCH_LIMIT, limit);
    write_reg(CFG_STEP_GAIN, gain);
  endtask

  task automatic white_run(input int n);
    repeat (n) send_frame(make_frame(PAT_ALL_WHITE, 1'b1, 8'($urandom_range(1, 255))));
  endtask

  task automatic run_phase(input int n, input int max_run);
    int k;
    int len;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, max_run);
        white_run(len);
        k += len;
      end else begin
        send_frame(random_frame());
        k++;
      end
      if ($urandom_range(0, 59) == 0) settle();
    end
  endtask

  initial begin : result_sink
    int hold;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 11);
        res_ch.ready = 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("line_follow_steering_core_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int lim;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset register values
    send_frame(make_frame(4'b1111, 1'b0, 8'd50));
    send_frame(make_frame(PAT_HALF_RIGHT, 1'b1, 8'd0));
    send_frame(make_frame(PAT_ALL_WHITE, 1'b1, 8'd60));
    for (int p = 1; p < 16; p++) send_frame(make_frame(4'(p), 1'b1, 8'd50));
    send_frame(make_frame(PAT_ALL_WHITE, 1'b1, 8'd40));
    send_frame(make_frame(4'b1111, 1'b1, 8'd255));
    send_frame(make_frame(4'b0010, 1'b1, 8'd1));
    send_frame(make_frame(PAT_HALF_RIGHT, 1'b1, 8'd255));
    send_frame(make_frame(PAT_HALF_LEFT, 1'b1, 8'd255));
    white_run(128);

    set_regs(8'd0, 8'd0);
    send_frame(make_frame(PAT_HALF_RIGHT, 1'b1, 8'd80));
    send_frame(make_frame(PAT_ALL_WHITE, 1'b1, 8'd30));
    run_phase(100, 4);

    set_regs(8'd255, 8'd15);
    run_phase(100, 8);
    white_run(260);

    repeat (3) begin
      lim = $urandom_range(0, 20);
      set_regs(8'(lim), 8'($urandom_range(0, 255)));
      run_phase(100, lim + 4);
    end

    set_regs(8'($urandom_range(0, 12)), 8'($urandom_range(0, 15)));
    idle_on = 1'b0;
    run_phase(100, 6);

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("line_follow_steering_core_tb: done, clean");
    end else begin
      $display("line_follow_steering_core_tb: done, errors");
    end
    $finish;
  end

endmodule
